// ===== rtl/gpf_pkg.sv =====
package gpf_pkg;

	localparam int WINDOW_LEN   = 50;
	localparam int TICK_RATE_HZ = 1000;
	localparam int LOST_LIMIT   = 10;
	localparam int OUTPUT_LIMIT = 10000;

	localparam int ANGLE_W  = 16;
	localparam int DIFF_W   = ANGLE_W + 1;
	localparam int GAIN_W   = 16;
	localparam int ILIM_W   = 15;
	localparam int MISS_W   = 4;
	localparam int SLOT_W   = $clog2(WINDOW_LEN);
	localparam int GSUM_W   = $clog2(WINDOW_LEN * 15 + 1);
	localparam int RING_W   = ANGLE_W + MISS_W;
	localparam int SPEED_W  = 32;
	localparam int INTEG_W  = 32;
	localparam int DRIVE_W  = 15;
	localparam int DIVD_W   = $clog2(65535 * TICK_RATE_HZ + 1);
	localparam int DCNT_W   = $clog2(DIVD_W + 1);
	localparam int MUL_A_W  = 32;
	localparam int MUL_B_W  = GAIN_W + 1;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic                      encoder_fresh;
		logic signed [ANGLE_W-1:0] encoder_angle;
	} sample_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive_current;
		logic signed [SPEED_W-1:0] speed_estimate;
	} command_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT  = 3'd0,
		REG_GAIN_P    = 3'd1,
		REG_GAIN_I    = 3'd2,
		REG_GAIN_D    = 3'd3,
		REG_INT_LIMIT = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		MUL_DIFF_RATE,
		MUL_ERR_I,
		MUL_ERR_P,
		MUL_SPD_D
	} mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TICK,
		ST_RATE,
		ST_DIV_START,
		ST_DIV,
		ST_SPEED,
		ST_ERR,
		ST_MUL_I,
		ST_INT,
		ST_MUL_P,
		ST_ACC,
		ST_SUB,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     ring_upd;
		logic     miss_upd;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     div_start;
		logic     spd_upd;
		logic     err_upd;
		logic     int_upd;
		logic     acc_init;
		logic     acc_sub;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic fresh;
		logic div_last;
	} dp_status_t;

endpackage

// ===== rtl/gpf_div.sv =====
module gpf_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [gpf_pkg::DIVD_W-1:0]     dividend,
	input  logic [gpf_pkg::GSUM_W-1:0]     divisor,
	output logic                           last,
	output logic [gpf_pkg::DIVD_W-1:0]     quotient
);
	import gpf_pkg::*;

	logic [DCNT_W-1:0] cnt_q;
	logic [DIVD_W-1:0] dvd_q;
	logic [GSUM_W-1:0] rem_q;
	logic [GSUM_W-1:0] dsr_q;
	logic [GSUM_W:0]   rem_sh;
	logic              qbit;

	always_comb begin
		rem_sh = {rem_q, dvd_q[DIVD_W-1]};
		qbit   = (rem_sh >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DCNT_W'(DIVD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DIVD_W-2:0], qbit};
			if (qbit) begin
				rem_q <= GSUM_W'(rem_sh - {1'b0, dsr_q});
			end else begin
				rem_q <= rem_sh[GSUM_W-1:0];
			end
		end
	end

	assign last     = (cnt_q == DCNT_W'(1));
	assign quotient = dvd_q;

endmodule

// ===== rtl/gpf_datapath.sv =====
module gpf_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gpf_pkg::dp_cmd_t                cmd,
	output gpf_pkg::dp_status_t             status,
	input  gpf_pkg::sample_t                sample,
	output gpf_pkg::command_t               command,
	input  logic                            cfg_we,
	input  logic [gpf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gpf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import gpf_pkg::*;

	logic signed [ANGLE_W-1:0] setpoint_q;
	logic [GAIN_W-1:0]         gain_p_q;
	logic [GAIN_W-1:0]         gain_i_q;
	logic [GAIN_W-1:0]         gain_d_q;
	logic [ILIM_W-1:0]         ilim_q;

	logic                      fresh_q;
	logic signed [ANGLE_W-1:0] angle_q;

	logic [RING_W-1:0]         ring_mem [WINDOW_LEN];
	logic [RING_W-1:0]         ring_rd_q;
	logic [WINDOW_LEN-1:0]     ring_vld_q;
	logic [SLOT_W-1:0]         slot_q;
	logic [MISS_W-1:0]         miss_q;
	logic [GSUM_W-1:0]         gsum_q;
	logic signed [ANGLE_W-1:0] latest_angle_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic signed [INTEG_W-1:0] integ_q;

	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [DIFF_W-1:0]  err_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      neg_q;
	command_t                  command_q;

	logic signed [ANGLE_W-1:0] ring_angle;
	logic [MISS_W-1:0]         ring_gap;
	logic [MISS_W:0]           miss_inc;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_mag;
	logic [DIVD_W-1:0]         div_dvd;
	logic [DIVD_W-1:0]         div_quot;
	logic                      div_last;
	logic signed [SPEED_W-1:0] quot_ext;
	logic signed [ACC_W-1:0]   integ_w;
	logic signed [ACC_W-1:0]   ilim_w;
	logic signed [ACC_W-1:0]   integ_clamp;
	logic signed [ACC_W-1:0]   drive_w;
	logic signed [ACC_W-1:0]   drive_sat;

	localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(OUTPUT_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			gain_p_q   <= '0;
			gain_i_q   <= '0;
			gain_d_q   <= '0;
			ilim_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SETPOINT:  setpoint_q <= $signed(cfg_data[ANGLE_W-1:0]);
				REG_GAIN_P:    gain_p_q   <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:    gain_i_q   <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:    gain_d_q   <= cfg_data[GAIN_W-1:0];
				REG_INT_LIMIT: ilim_q     <= cfg_data[ILIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			fresh_q <= sample.encoder_fresh;
			angle_q <= sample.encoder_angle;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ring_upd) begin
			ring_mem[slot_q] <= {angle_q, miss_q};
		end
		ring_rd_q <= ring_mem[slot_q];
	end

	always_comb begin
		if (ring_vld_q[slot_q]) begin
			ring_angle = $signed(ring_rd_q[RING_W-1:MISS_W]);
			ring_gap   = ring_rd_q[MISS_W-1:0];
		end else begin
			ring_angle = '0;
			ring_gap   = '0;
		end
		miss_inc = {1'b0, miss_q} + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q     <= '0;
			slot_q         <= '0;
			miss_q         <= '0;
			gsum_q         <= '0;
			latest_angle_q <= '0;
			speed_q        <= '0;
			integ_q        <= '0;
		end else begin
			if (cmd.ring_upd) begin
				ring_vld_q[slot_q] <= 1'b1;
				slot_q <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
				gsum_q <= gsum_q + GSUM_W'(miss_q) - GSUM_W'(ring_gap);
				latest_angle_q <= angle_q;
				miss_q <= MISS_W'(1);
			end
			if (cmd.miss_upd) begin
				miss_q <= (miss_inc > (MISS_W+1)'(LOST_LIMIT)) ? MISS_W'(1)
					: miss_inc[MISS_W-1:0];
			end
			if (cmd.spd_upd) begin
				if (gsum_q == '0) begin
					speed_q <= '0;
				end else begin
					speed_q <= neg_q ? -quot_ext : quot_ext;
				end
			end
			if (cmd.int_upd) begin
				integ_q <= integ_clamp[INTEG_W-1:0];
			end
		end
	end

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_DIFF_RATE: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = MUL_B_W'(TICK_RATE_HZ);
			end
			MUL_ERR_I: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = $signed({1'b0, gain_i_q});
			end
			MUL_ERR_P: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = $signed({1'b0, gain_p_q});
			end
			MUL_SPD_D: begin
				mul_a = speed_q;
				mul_b = $signed({1'b0, gain_d_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		prod_mag = prod_q[PROD_W-1] ? -prod_q : prod_q;
		div_dvd  = prod_mag[DIVD_W-1:0];
		quot_ext = $signed({{(SPEED_W-DIVD_W){1'b0}}, div_quot});

		integ_w = ACC_W'(integ_q) + ACC_W'(prod_q >>> 4);
		ilim_w  = $signed(ACC_W'({ilim_q, 16'b0}));
		if (integ_w > ilim_w) begin
			integ_clamp = ilim_w;
		end else if (integ_w < -ilim_w) begin
			integ_clamp = -ilim_w;
		end else begin
			integ_clamp = integ_w;
		end

		drive_w = acc_q >>> 20;
		if (drive_w > OUT_MAX) begin
			drive_sat = OUT_MAX;
		end else if (drive_w < -OUT_MAX) begin
			drive_sat = -OUT_MAX;
		end else begin
			drive_sat = drive_w;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ring_upd) begin
			diff_q <= DIFF_W'(angle_q) - DIFF_W'(ring_angle);
		end
		if (cmd.err_upd) begin
			err_q <= DIFF_W'(setpoint_q) - DIFF_W'(latest_angle_q);
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.div_start) begin
			neg_q <= prod_q[PROD_W-1];
		end
		if (cmd.acc_init) begin
			acc_q <= ACC_W'(prod_q) + (ACC_W'(integ_q) <<< 4);
		end else if (cmd.acc_sub) begin
			acc_q <= acc_q - ACC_W'(prod_q);
		end
		if (cmd.out_load) begin
			command_q.drive_current  <= drive_sat[DRIVE_W-1:0];
			command_q.speed_estimate <= speed_q;
		end
	end

	gpf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (gsum_q),
		.last     (div_last),
		.quotient (div_quot)
	);

	assign status.fresh    = fresh_q;
	assign status.div_last = div_last;
	assign command         = command_q;

endmodule

// ===== rtl/gpf_ctrl.sv =====
module gpf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	output logic                 command_valid,
	input  logic                 command_stall,
	input  gpf_pkg::dp_status_t  status,
	output gpf_pkg::dp_cmd_t     cmd
);
	import gpf_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   valid_q;
	logic   out_free;

	assign out_free = !valid_q || !command_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				valid_q <= 1'b1;
			end else if (!command_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.mul_sel  = MUL_DIFF_RATE;
		sample_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_TICK;
				end
			end
			ST_TICK: begin
				if (status.fresh) begin
					cmd.ring_upd = 1'b1;
					state_d      = ST_RATE;
				end else begin
					cmd.miss_upd = 1'b1;
					state_d      = ST_ERR;
				end
			end
			ST_RATE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DIFF_RATE;
				state_d     = ST_DIV_START;
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_last) begin
					state_d = ST_SPEED;
				end
			end
			ST_SPEED: begin
				cmd.spd_upd = 1'b1;
				state_d     = ST_ERR;
			end
			ST_ERR: begin
				cmd.err_upd = 1'b1;
				state_d     = ST_MUL_I;
			end
			ST_MUL_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ERR_I;
				state_d     = ST_INT;
			end
			ST_INT: begin
				cmd.int_upd = 1'b1;
				state_d     = ST_MUL_P;
			end
			ST_MUL_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ERR_P;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_init = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_SPD_D;
				state_d      = ST_SUB;
			end
			ST_SUB: begin
				cmd.acc_sub = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign command_valid = valid_q;

endmodule

// ===== rtl/gimbal_position_pid_with_speed_fir_top.sv =====
// channel   dir  handshake                      word
// sample    in   sample_valid / sample_stall    encoder_fresh, encoder_angle
// command   out  command_valid / command_stall  drive_current, speed_estimate
// cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// A fresh word runs the rate product through the one-bit-per-cycle speed divider;
// a missed-sample word skips the divider and goes straight to the shared multiplier.
// Reset clears the window ring through per-slot valid bits; no clearing pass.
// A finished word waits in the command register while the next sample is taken;
// the sequencer holds before loading only while that register is still stalled.
module gimbal_position_pid_with_speed_fir_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  gpf_pkg::sample_t                sample,
	output logic                            command_valid,
	input  logic                            command_stall,
	output gpf_pkg::command_t               command,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gpf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gpf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import gpf_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	gpf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.command_valid (command_valid),
		.command_stall (command_stall),
		.status        (status),
		.cmd           (cmd)
	);

	gpf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.sample    (sample),
		.command   (command),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gpf_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES    = 64;
	localparam int NUM_PHASES    = 6;
	localparam int PHASE_ITEMS   = 172;
	localparam longint TIMEOUT_NS = 64'd20_000_000;
	localparam longint SPEED_MAX  = 64'sd2147483647;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_INT_LIMIT) + 1'b1;

	typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   index;
		logic [CFG_DATA_W-1:0]  data;
		logic                   fresh;
		logic                   typed;
		logic [DRIVE_W-1:0]     drive;
		logic [SPEED_W-1:0]     speed;
	} dir_row_t;

	localparam int DIR_COUNT = 33;
	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		'{ROW_WORD, REG_SETPOINT,  16'h7FFF, 1'b1, 1'b1, 15'd0, 32'd0},
		'{ROW_WORD, REG_SETPOINT,  16'h8000, 1'b0, 1'b1, 15'd0, 32'd0},
		'{ROW_WORD, REG_SETPOINT,  16'h8000, 1'b1, 1'b1, 15'd0, -32'sd16384000},
		'{ROW_WORD, REG_SETPOINT,  16'h7FFF, 1'b0, 1'b1, 15'd0, -32'sd16384000},
		'{ROW_WORD, REG_SETPOINT,  16'h8000, 1'b0, 1'b1, 15'd0, -32'sd16384000},
		'{ROW_WORD, REG_SETPOINT,  16'hFFFF, 1'b0, 1'b1, 15'd0, -32'sd16384000},
		'{ROW_WORD, REG_SETPOINT,  16'h0000, 1'b0, 1'b1, 15'd0, -32'sd16384000},
		'{ROW_WORD, REG_SETPOINT,  16'h5555, 1'b0, 1'b1, 15'd0, -32'sd16384000},
		'{ROW_WORD, REG_SETPOINT,  16'hAAAA, 1'b0, 1'b1, 15'd0, -32'sd16384000},
		'{ROW_WORD, REG_SETPOINT,  16'h0001, 1'b0, 1'b1, 15'd0, -32'sd16384000},
		'{ROW_WORD, REG_SETPOINT,  16'h1234, 1'b0, 1'b1, 15'd0, -32'sd16384000},
		'{ROW_WORD, REG_SETPOINT,  16'hEDCB, 1'b0, 1'b1, 15'd0, -32'sd16384000},
		'{ROW_WORD, REG_SETPOINT,  16'h7FFF, 1'b0, 1'b1, 15'd0, -32'sd16384000},
		'{ROW_WORD, REG_SETPOINT,  16'h8000, 1'b0, 1'b1, 15'd0, -32'sd16384000},
		'{ROW_WORD, REG_SETPOINT,  16'h0000, 1'b1, 1'b1, 15'd0, 32'd0},
		'{ROW_CFG,  REG_SETPOINT,  16'h7FFF, 1'b0, 1'b0, 15'd0, 32'd0},
		'{ROW_CFG,  REG_GAIN_P,    16'hFFFF, 1'b0, 1'b0, 15'd0, 32'd0},
		'{ROW_CFG,  REG_GAIN_I,    16'hFFFF, 1'b0, 1'b0, 15'd0, 32'd0},
		'{ROW_CFG,  REG_GAIN_D,    16'hFFFF, 1'b0, 1'b0, 15'd0, 32'd0},
		'{ROW_CFG,  REG_INT_LIMIT, 16'hFFFF, 1'b0, 1'b0, 15'd0, 32'd0},
		'{ROW_CFG,  REG_SPARE,     16'h8000, 1'b0, 1'b0, 15'd0, 32'd0},
		'{ROW_WORD, REG_SETPOINT,  16'h8000, 1'b1, 1'b0, 15'd0, 32'd0},
		'{ROW_WORD, REG_SETPOINT,  16'h7FFF, 1'b1, 1'b0, 15'd0, 32'd0},
		'{ROW_WORD, REG_SETPOINT,  16'h1234, 1'b0, 1'b0, 15'd0, 32'd0},
		'{ROW_WORD, REG_SETPOINT,  16'h0001, 1'b1, 1'b0, 15'd0, 32'd0},
		'{ROW_WORD, REG_SETPOINT,  16'hFFFF, 1'b1, 1'b0, 15'd0, 32'd0},
		'{ROW_CFG,  REG_SETPOINT,  16'h8000, 1'b0, 1'b0, 15'd0, 32'd0},
		'{ROW_CFG,  REG_GAIN_P,    16'h0100, 1'b0, 1'b0, 15'd0, 32'd0},
		'{ROW_CFG,  REG_GAIN_I,    16'h0000, 1'b0, 1'b0, 15'd0, 32'd0},
		'{ROW_CFG,  REG_GAIN_D,    16'h0000, 1'b0, 1'b0, 15'd0, 32'd0},
		'{ROW_CFG,  REG_INT_LIMIT, 16'h0000, 1'b0, 1'b0, 15'd0, 32'd0},
		'{ROW_WORD, REG_SETPOINT,  16'h7FFF, 1'b1, 1'b0, 15'd0, 32'd0},
		'{ROW_WORD, REG_SETPOINT,  16'h0000, 1'b0, 1'b0, 15'd0, 32'd0}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    sample_valid;
	logic                    sample_stall;
	sample_t                 sample;
	logic                    command_valid;
	logic                    command_stall;
	command_t                command;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	command_t pending_commands [$];
	command_t want_cmd;
	int       mismatches;
	bit       idle_on;
	int       stall_left;

	longint set_angle;
	longint kp;
	longint ki;
	longint kd;
	longint integ_lim;

	int     win_angle [WINDOW_LEN];
	int     win_gaps [WINDOW_LEN];
	int     win_total;
	int     win_next;
	int     miss_count;
	longint held_angle;
	longint held_speed;
	longint integ_q16;

	gimbal_position_pid_with_speed_fir_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.command_valid (command_valid),
		.command_stall (command_stall),
		.command       (command),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic command_t step_controller(input sample_t w);
		longint diff;
		longint rate_est;
		longint err;
		longint lim;
		longint acc;
		longint total;
		longint drv;
		command_t c;
		if (w.encoder_fresh) begin
			win_total = win_total + miss_count - win_gaps[win_next];
			diff = longint'($signed(w.encoder_angle)) - longint'(win_angle[win_next]);
			rate_est = 0;
			if (win_total != 0) begin
				rate_est = diff * TICK_RATE_HZ / win_total;
				if (rate_est > SPEED_MAX)
					rate_est = SPEED_MAX;
				if (rate_est < -SPEED_MAX)
					rate_est = -SPEED_MAX;
			end
			win_angle[win_next] = $signed(w.encoder_angle);
			win_gaps[win_next] = miss_count;
			win_next = (win_next + 1) % WINDOW_LEN;
			held_angle = $signed(w.encoder_angle);
			held_speed = rate_est;
			miss_count = 1;
		end else begin
			miss_count++;
			if (miss_count > LOST_LIMIT)
				miss_count = 1;
		end
		err = set_angle - held_angle;
		lim = integ_lim <<< 16;
		acc = integ_q16 + ((err * ki) >>> 4);
		if (acc > lim)
			acc = lim;
		if (acc < -lim)
			acc = -lim;
		integ_q16 = acc;
		total = err * kp + acc * 16 - held_speed * kd;
		drv = total >>> 20;
		if (drv > OUTPUT_LIMIT)
			drv = OUTPUT_LIMIT;
		if (drv < -OUTPUT_LIMIT)
			drv = -OUTPUT_LIMIT;
		c.drive_current = drv[DRIVE_W-1:0];
		c.speed_estimate = held_speed[SPEED_W-1:0];
		return c;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("tb: mismatch on %s at %0t: got %0d, want %0d", what, $realtime, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && command_valid && !command_stall) begin
			if (pending_commands.size() == 0) begin
				report_mismatch("unexpected word", $signed(command.drive_current), 0);
			end else begin
				want_cmd = pending_commands.pop_front();
				if (command.drive_current !== want_cmd.drive_current)
					report_mismatch("drive_current", $signed(command.drive_current),
						$signed(want_cmd.drive_current));
				if (command.speed_estimate !== want_cmd.speed_estimate)
					report_mismatch("speed_estimate", $signed(command.speed_estimate),
						$signed(want_cmd.speed_estimate));
			end
		end
		if (stall_left > 0) begin
			stall_left--;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 18);
		end
		command_stall <= (stall_left > 0);
	end

	task automatic send_word(input sample_t w, input bit typed, input command_t typed_cmd);
		command_t want;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= w;
		do @(posedge clk); while (sample_stall);
		want = step_controller(w);
		pending_commands.push_back(typed ? typed_cmd : want);
	endtask

	task automatic settle();
		sample_valid <= 1'b0;
		while (pending_commands.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SETPOINT:  set_angle = longint'($signed(data));
			REG_GAIN_P:    kp = data;
			REG_GAIN_I:    ki = data;
			REG_GAIN_D:    kd = data;
			REG_INT_LIMIT: integ_lim = data[ILIM_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_setting(input logic [CFG_DATA_W-1:0] top);
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return top;
			2, 3:    return CFG_DATA_W'($urandom_range(0, 1024));
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	task automatic load_random_settings();
		logic [CFG_DATA_W-1:0] lim;
		settle();
		write_register(REG_SETPOINT, CFG_DATA_W'($urandom));
		write_register(REG_GAIN_P, pick_setting('1));
		write_register(REG_GAIN_I, pick_setting('1));
		write_register(REG_GAIN_D, pick_setting('1));
		lim = pick_setting({1'b0, {ILIM_W{1'b1}}});
		write_register(REG_INT_LIMIT, {1'($urandom), lim[ILIM_W-1:0]});
		if ($urandom_range(0, 1))
			write_register(CFG_IDX_W'($urandom_range(REG_SPARE, (1 << CFG_IDX_W) - 1)),
				CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random_phase(input int count);
		int sent;
		int len;
		int angle;
		int rate;
		sample_t w;
		command_t none;
		sent = 0;
		none = '0;
		while (sent < count) begin
			case ($urandom_range(0, 9))
				7: begin
					// dropout that may run long enough to wrap the missed-tick count
					len = $urandom_range(8, 14);
					for (int k = 0; k < len; k++) begin
						w.encoder_fresh = 1'b0;
						w.encoder_angle = ANGLE_W'($urandom);
						send_word(w, 1'b0, none);
					end
				end
				8, 9: begin
					len = $urandom_range(1, 10);
					for (int k = 0; k < len; k++) begin
						w = sample_t'($urandom);
						send_word(w, 1'b0, none);
					end
				end
				default: begin
					// track a moving target with occasional lost samples
					angle = $urandom;
					if ($urandom_range(0, 4) == 0)
						rate = $signed(ANGLE_W'($urandom));
					else
						rate = int'($urandom_range(0, 400)) - 200;
					len = $urandom_range(5, 40);
					for (int k = 0; k < len; k++) begin
						angle = angle + rate + int'($urandom_range(0, 8)) - 4;
						w.encoder_fresh = ($urandom_range(0, 6) != 0);
						w.encoder_angle = angle[ANGLE_W-1:0];
						send_word(w, 1'b0, none);
					end
				end
			endcase
			sent += len;
		end
	endtask

	initial begin
		sample_t  w;
		command_t typed_cmd;
		bit       cfg_open;
		clk = 1'b0;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		command_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		idle_on = 1'b1;
		stall_left = 0;
		set_angle = 0;
		kp = 0;
		ki = 0;
		kd = 0;
		integ_lim = 0;
		foreach (win_angle[i]) begin
			win_angle[i] = 0;
			win_gaps[i] = 0;
		end
		win_total = 0;
		win_next = 0;
		miss_count = 0;
		held_angle = 0;
		held_speed = 0;
		integ_q16 = 0;
		cfg_open = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_COUNT; i++) begin
			if (DIR_ROWS[i].kind == ROW_CFG) begin
				if (!cfg_open)
					settle();
				cfg_open = 1'b1;
				write_register(DIR_ROWS[i].index, DIR_ROWS[i].data);
			end else begin
				if (cfg_open)
					cfg_valid <= 1'b0;
				cfg_open = 1'b0;
				w.encoder_fresh = DIR_ROWS[i].fresh;
				w.encoder_angle = DIR_ROWS[i].data;
				typed_cmd.drive_current = DIR_ROWS[i].drive;
				typed_cmd.speed_estimate = DIR_ROWS[i].speed;
				send_word(w, DIR_ROWS[i].typed, typed_cmd);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			load_random_settings();
			idle_on = (p != NUM_PHASES - 1);
			run_random_phase(PHASE_ITEMS);
		end

		sample_valid <= 1'b0;
		while (pending_commands.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/gpf_pkg.sv
rtl/gpf_div.sv
rtl/gpf_datapath.sv
rtl/gpf_ctrl.sv
rtl/gimbal_position_pid_with_speed_fir_top.sv
tb/tb.sv
